[src/strided_slice_index_normalizer_defines.svh]
// assertion macros shared by the checker
`ifndef STRIDED_SLICE_INDEX_NORMALIZER_DEFINES_SVH
`define STRIDED_SLICE_INDEX_NORMALIZER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define SSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ssn_pkg.sv]
package ssn_pkg;
  localparam int unsigned NUM_DIMS = 6;
  localparam int unsigned W = 34;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_DIR  = 2'd2
  } status_t;

  // request travelling down the cell row: remainder division state plus results
  typedef struct packed {
    logic            div_en;
    logic [W-1:0]    rem;
    logic [W-1:0]    quo;
    logic [W-1:0]    num;
    logic [31:0]     dvs;
    logic            len_div;
    logic signed [W-1:0] len;
    logic signed [W-1:0] s;
    logic signed [W-1:0] e;
    // reverse offset numerator, last - e, may be negative
    logic signed [W-1:0] onum;
    logic [31:0]     step;
    logic            rev;
    logic            fix;
    status_t         status;
  } cell_t;
endpackage

[src/strided_slice_index_normalizer.sv]
// Strided slice index normalizer.
// in_*  : one slice request per item; out_* : one result per request, in order.
// cfg_* : write port for the six axis sizes (index 0..5) and the squeeze mask
//         (index 6); write only while no request is in flight.
// Length and reverse offset come from restoring dividers built as two rows of
// 34 cells each, one quotient bit per cell, so a request passes the front
// stage, 34 length cells, a merge stage, 34 offset cells and a final stage.
// Throughput is one request per cycle while results are taken; every cell
// hands its request to the next each cycle the row moves.
// When out_tready is low while a result is shown, the whole row holds and
// in_tready falls, unless the row has a bubble, then it keeps filling.
// Reset clears all valid bits, the axis sizes to 0 and the mask to 0.
module strided_slice_index_normalizer #(
  parameter int unsigned MAX_RANK = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // axis_number[2:0], start_idx[34:3], end_idx[66:35], stride_value[98:67],
  // infer_unknown[99], zero fill to 104
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_length[31:0], begin_out[63:32], end_out[95:64], step_out[126:96],
  // reverse_flag[127], status[129:128], zero fill to 136
  output logic [135:0] out_tdata,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import ssn_pkg::*;

  localparam int unsigned NCELL = 2 * W + 3;

  logic signed [31:0] dim_r [6];
  logic [5:0]         mask_r;
  logic [5:0]         mask_eff;
  cell_t              row [NCELL-1];
  cell_t              mid_in;
  cell_t              out_r;
  logic [NCELL-1:0]   adv;
  logic [NCELL-1:0]   vld_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) dim_r[i] <= '0;
      mask_r <= '0;
    end else if (cfg_wen) begin
      if (cfg_index < 3'(NUM_DIMS)) dim_r[cfg_index] <= cfg_wdata;
      else if (cfg_index == 3'(NUM_DIMS)) mask_r <= cfg_wdata[5:0];
    end
  end

  // axes at or above the rank behave as unknown and unsqueezed
  logic signed [31:0] dim_eff [6];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dim_eff[i] = (i < MAX_RANK) ? dim_r[i] : -32'sd1;
      mask_eff[i] = (i < MAX_RANK) ? mask_r[i] : 1'b0;
    end
  end

  // row advance: a cell moves when the cell after it moves or is empty
  always_comb begin
    adv[NCELL-1] = !vld_r[NCELL-1] || out_tready;
    for (int i = NCELL - 2; i >= 0; i--) adv[i] = !vld_r[i] || adv[i+1];
  end
  assign in_tready = adv[0];

  ssn_front u_front (
    .clk, .adv(adv[0]),
    .axis_number(in_tdata[2:0]), .start_idx(in_tdata[34:3]),
    .end_idx(in_tdata[66:35]), .stride_value(in_tdata[98:67]),
    .infer_unknown(in_tdata[99]), .dim_size(dim_eff), .squeeze_mask(mask_eff),
    .cell_r(row[0])
  );

  // length divider row
  for (genvar g = 0; g < W; g++) begin : g_len
    ssn_div_cell #(.BIT(W - 1 - g)) u_cell (
      .clk, .adv(adv[g+1]), .cell_in(row[g]), .cell_r(row[g+1])
    );
  end

  // take length quotient, set up offset division on the magnitude
  always_comb begin
    mid_in = row[W];
    if (row[W].len_div) mid_in.len = row[W].quo;
    mid_in.div_en = 1'b0;
    mid_in.rem = '0;
    mid_in.quo = '0;
    mid_in.num = '0;
    mid_in.len_div = 1'b0;
    if (row[W].fix) begin
      mid_in.div_en = 1'b1;
      mid_in.num = (row[W].onum < 0) ? -row[W].onum : row[W].onum;
    end
  end

  // merge register
  ssn_back u_mid (.clk, .adv(adv[W+1]), .cell_in(mid_in), .cell_r(row[W+1]));

  // offset divider row
  for (genvar g = 0; g < W; g++) begin : g_off
    ssn_div_cell #(.BIT(W - 1 - g)) u_cell (
      .clk, .adv(adv[W+2+g]), .cell_in(row[W+1+g]), .cell_r(row[W+2+g])
    );
  end

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NCELL; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // final apply of reverse offset and saturation
  cell_t fin;
  always_comb begin
    logic signed [W-1:0] off, b, e;
    fin = row[NCELL-2];
    off = fin.rem;
    // remainder takes the sign of the numerator
    if (fin.onum < 0) off = -off;
    if (off == 0) off = W'(fin.step);
    b = fin.s;
    e = fin.e;
    if (fin.fix) begin
      b = b + off;
      e = e + off;
    end
    if (fin.rev) begin
      fin.s = e;
      fin.e = b;
    end else begin
      fin.s = b;
      fin.e = e;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NCELL-1]) out_r <= fin;
  end

  function automatic logic [31:0] sat(input logic signed [W-1:0] v);
    if (v > W'(32'sh7fffffff)) return 32'h7fffffff;
    if (v < -W'(33'sh80000000)) return 32'h80000000;
    return v[31:0];
  endfunction

  assign out_tvalid = vld_r[NCELL-1];
  assign out_tdata = {6'd0, out_r.status, out_r.rev,
                      (out_r.step[31] ? 31'h7fffffff : out_r.step[30:0]),
                      sat(out_r.e), sat(out_r.s),
                      out_r.len[31:0]};
endmodule

[src/ssn_front.sv]
// front stage: index normalization, picks what the division must do
module ssn_front (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [2:0]           axis_number,
  input  logic signed [31:0]   start_idx,
  input  logic signed [31:0]   end_idx,
  input  logic signed [31:0]   stride_value,
  input  logic                 infer_unknown,
  input  logic signed [31:0]   dim_size [6],
  input  logic [5:0]           squeeze_mask,
  output ssn_pkg::cell_t       cell_r
);
  import ssn_pkg::*;

  cell_t cell_nxt;

  always_comb begin
    logic signed [W-1:0] d, s0, e0, st, a, c, lo, hi, ab, s, e, last;
    logic in_mask, sq, neg, known;
    cell_nxt = '0;
    if (axis_number < 3'(NUM_DIMS)) begin
      d = W'(dim_size[axis_number]);
      in_mask = squeeze_mask[axis_number];
    end else begin
      d = -W'(1);
      in_mask = 1'b0;
    end
    s0 = W'(start_idx);
    e0 = W'(end_idx);
    st = W'(stride_value);
    neg = st < 0;
    known = d >= 0;
    sq = (s0 == -1) && (e0 == 0) && infer_unknown && in_mask;
    ab = neg ? -st : st;
    // python style wrap of start and end
    a = s0;
    if (a < 0) begin
      a = a + d;
      if (a < 0) a = '0;
    end
    c = e0;
    if (c < 0 && !(c == -1 && neg)) begin
      c = c + d;
      if (c < 0) c = '0;
    end
    s = a;
    e = sq ? (neg ? a - 1 : a + 1) : c;
    if (neg) begin
      a = a + 1;
      c = c + 1;
    end
    lo = (a < c) ? a : c;
    if (lo < 0) lo = '0;
    hi = (a > c) ? a : c;
    if (hi > d) hi = d;
    last = (d - 1 < s) ? d - 1 : s;
    cell_nxt.dvs = ab[31:0];
    cell_nxt.s = s;
    cell_nxt.e = e;
    cell_nxt.step = ab[31:0];
    cell_nxt.rev = neg;
    if (!sq && st == 0) begin
      cell_nxt.status = ST_ZERO;
      cell_nxt.s = '0;
      cell_nxt.e = '0;
      cell_nxt.step = '0;
      cell_nxt.rev = 1'b0;
    end else if (!known) begin
      cell_nxt.len = sq ? W'(1) : d;
      cell_nxt.s = '0;
      cell_nxt.e = W'(1);
      cell_nxt.step = 32'd1;
      cell_nxt.rev = 1'b0;
    end else if (!sq && ((neg && a < c) || (!neg && a > c))) begin
      cell_nxt.status = ST_DIR;
      cell_nxt.s = '0;
      cell_nxt.e = '0;
      cell_nxt.step = '0;
      cell_nxt.rev = 1'b0;
    end else begin
      cell_nxt.len = sq ? W'(1) : '0;
      cell_nxt.len_div = !sq && (hi > lo);
      // reverse offset uses (last - e) rem step, length uses ceil((hi-lo)/step)
      cell_nxt.fix = neg && (s > e);
      cell_nxt.onum = last - e;
      if (cell_nxt.len_div) begin
        cell_nxt.div_en = 1'b1;
        cell_nxt.num = hi - lo + ab - 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cell_r <= cell_nxt;
  end
endmodule

[src/ssn_div_cell.sv]
// one restoring division step per cell
module ssn_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk,
  input  logic            adv,
  input  ssn_pkg::cell_t  cell_in,
  output ssn_pkg::cell_t  cell_r
);
  import ssn_pkg::*;

  cell_t cell_nxt;

  always_comb begin
    logic [W:0] trial;
    cell_nxt = cell_in;
    trial = {cell_in.rem, cell_in.num[BIT]};
    if (cell_in.div_en) begin
      if (trial >= {3'b0, cell_in.dvs}) begin
        cell_nxt.rem = W'(trial - {3'b0, cell_in.dvs});
        cell_nxt.quo[BIT] = 1'b1;
      end else begin
        cell_nxt.rem = W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cell_r <= cell_nxt;
  end
endmodule

[src/ssn_back.sv]
// merge stage register between the length row and the offset row
module ssn_back (
  input  logic            clk,
  input  logic            adv,
  input  ssn_pkg::cell_t  cell_in,
  output ssn_pkg::cell_t  cell_r
);
  import ssn_pkg::*;

  cell_t cell_nxt;

  always_comb begin
    cell_nxt = cell_in;
    if (cell_in.len_div) begin
      cell_nxt.len = cell_in.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cell_r <= cell_nxt;
  end
endmodule

[src/ssn_checker.sv]
// port level checks of the normalizer
module ssn_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);
  import ssn_pkg::*;
`include "strided_slice_index_normalizer_defines.svh"

  `SSN_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SSN_ASSERT_IMP(a_status, clk, rst_n, out_tvalid, out_tdata[129:128] != 2'd3)
  `SSN_ASSERT_IMP(a_err_zero, clk, rst_n, out_tvalid && out_tdata[129:128] != ST_OK,
    out_tdata[127:0] == '0)
  `SSN_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready)
endmodule

bind strided_slice_index_normalizer ssn_checker u_ssn_checker (.*);
